@@ hdl/iatp_pkg.sv @@
`default_nettype none
package iatp_pkg;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_LEAD   = 3'd1,
        PH_BODY   = 3'd2,
        PH_COLON  = 3'd3,
        PH_DOTTED = 3'd4,
        PH_FAIL   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BAD    = 2'd1,
        ST_FAMILY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        FAM_V4 = 2'd0,
        FAM_V6 = 2'd1
    } t_family;

    typedef enum logic [1:0] {
        CT_IDLE,
        CT_SHIFT,
        CT_OUT
    } t_ctrl;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic       take;
        logic       start_shift;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic       term;
    } t_sts;

    function automatic logic [4:0] hex_val(input logic [7:0] ch);
        logic [4:0] v;
        v = 5'h10;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            v = {1'b0, ch[3:0]};
        end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
            v = {1'b0, ch[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hdl/iatp_datapath.sv @@
`default_nettype none
module iatp_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire iatp_pkg::t_cmd    i_cmd,
    input  wire logic [7:0]        i_character,
    input  wire logic [1:0]        i_family,
    output iatp_pkg::t_sts         o_sts,
    output logic [1:0]             o_status,
    output logic [63:0]            o_address_high,
    output logic [63:0]            o_address_low
);
    import iatp_pkg::*;

    logic [127:0] r_bytes, n_bytes;
    logic [4:0]   r_wpos, n_wpos;
    logic [4:0]   r_gpos, n_gpos;
    logic         r_gap, n_gap;
    logic [15:0]  r_grp, n_grp;
    logic         r_ghd, n_ghd;
    logic [7:0]   r_oct, n_oct;
    logic [2:0]   r_ocnt, n_ocnt;
    logic         r_ohd, n_ohd;
    logic         r_dec, n_dec;
    t_phase       r_ph, n_ph;
    logic [1:0]   r_fam, n_fam;
    logic [1:0]   r_st, n_st;
    logic [1:0]   r_status;
    logic [127:0] r_addr;

    logic [7:0]   ch;
    logic [4:0]   hv;
    logic         ok;
    logic [11:0]  dn;
    logic [4:0]   base;
    logic [4:0]   nshift;
    logic [127:0] lowmask;
    logic [127:0] kept, moved;
    logic         shift_ok;

    function automatic logic [127:0] put_byte(input logic [127:0] b, input logic [3:0] idx,
                                              input logic [7:0] v);
        logic [127:0] r;
        r = b;
        r[(7'd15 - {3'd0, idx}) * 8 +: 8] = v;
        return r;
    endfunction

    always_comb begin
        n_bytes = r_bytes; n_wpos = r_wpos; n_gpos = r_gpos; n_gap = r_gap;
        n_grp = r_grp; n_ghd = r_ghd; n_oct = r_oct; n_ocnt = r_ocnt; n_ohd = r_ohd;
        n_dec = r_dec; n_ph = r_ph; n_fam = r_fam; n_st = r_st;
        ch = i_character;
        hv = hex_val(ch);
        ok = 1'b1;
        dn = 12'd0;
        base = 5'd0;
        nshift = 5'd0;
        lowmask = '0;
        kept = '0;
        moved = '0;
        o_sts.term = 1'b0;
        shift_ok = 1'b0;
        if (i_cmd.take) begin
            if (r_ph == PH_START) begin
                n_bytes = '0; n_wpos = '0; n_gpos = '0; n_gap = 1'b0; n_grp = '0;
                n_ghd = 1'b0; n_oct = '0; n_ocnt = '0; n_ohd = 1'b0; n_dec = 1'b1;
                n_fam = i_family;
                n_ph = (i_family == FAM_V4) ? PH_DOTTED :
                       (i_family == FAM_V6) ? PH_BODY : PH_FAIL;
            end
            if (r_ph == PH_START && ch == CH_COLON && i_family == FAM_V6) begin
                n_ph = PH_LEAD;
            end else if (ch == CH_NUL) begin
                o_sts.term = 1'b1;
                n_st = ST_BAD;
                if (n_fam[1]) begin
                    n_st = ST_FAMILY;
                end else if (n_fam == FAM_V4) begin
                    if (n_ph == PH_DOTTED && n_ocnt == 3'd4 && n_ohd) begin
                        n_bytes = put_byte(n_bytes, 4'd3, n_oct);
                        n_st = ST_OK;
                    end
                end else if (n_ph == PH_DOTTED) begin
                    if (n_ocnt == 3'd4 && n_ohd) begin
                        n_bytes = put_byte(n_bytes, n_wpos[3:0] + 4'd3, n_oct);
                        n_wpos = n_wpos + 5'd4;
                        n_st = ST_OK;
                    end
                end else if (n_ph == PH_BODY) begin
                    n_st = ST_OK;
                    if (n_ghd) begin
                        if (n_wpos > 5'd14) begin
                            n_st = ST_BAD;
                        end else begin
                            n_bytes = put_byte(n_bytes, n_wpos[3:0], n_grp[15:8]);
                            n_bytes = put_byte(n_bytes, n_wpos[3:0] + 4'd1, n_grp[7:0]);
                            n_wpos = n_wpos + 5'd2;
                        end
                    end
                end
                if (n_fam == FAM_V6 && n_st == ST_OK) begin
                    if (n_gap) begin
                        if (n_wpos >= 5'd16 || n_gpos > n_wpos) n_st = ST_BAD;
                    end else if (n_wpos != 5'd16) begin
                        n_st = ST_BAD;
                    end
                end
            end else begin
                unique case (n_ph)
                    PH_LEAD: begin
                        if (ch == CH_COLON) begin
                            n_gap = 1'b1; n_gpos = '0; n_ph = PH_BODY;
                        end else begin
                            n_ph = PH_FAIL;
                        end
                    end
                    PH_BODY, PH_COLON: begin
                        n_ph = PH_BODY;
                        if (!hv[4]) begin
                            if (n_grp > 16'h0fff) begin
                                n_ph = PH_FAIL;
                            end else begin
                                n_grp = {n_grp[11:0], hv[3:0]};
                                n_ghd = 1'b1;
                                if (n_dec) begin
                                    dn = {4'd0, n_oct} * 12'd10 + {8'd0, hv[3:0]};
                                    if (hv > 5'd9 || ch > 8'h39 || (n_ohd && n_oct == 8'd0)
                                        || dn > 12'd255 || (!n_ohd && n_ocnt >= 3'd4)) begin
                                        n_dec = 1'b0;
                                    end else begin
                                        n_oct = dn[7:0];
                                        if (!n_ohd) begin
                                            n_ocnt = n_ocnt + 3'd1; n_ohd = 1'b1;
                                        end
                                    end
                                end
                            end
                        end else if (ch == CH_COLON) begin
                            n_oct = '0; n_ocnt = '0; n_ohd = 1'b0; n_dec = 1'b1;
                            if (!n_ghd) begin
                                if (n_gap) begin
                                    n_ph = PH_FAIL;
                                end else begin
                                    n_gap = 1'b1; n_gpos = n_wpos;
                                end
                            end else if (n_wpos > 5'd14) begin
                                n_ph = PH_FAIL;
                            end else begin
                                n_bytes = put_byte(n_bytes, n_wpos[3:0], n_grp[15:8]);
                                n_bytes = put_byte(n_bytes, n_wpos[3:0] + 4'd1, n_grp[7:0]);
                                n_wpos = n_wpos + 5'd2;
                                n_grp = '0; n_ghd = 1'b0;
                                n_ph = PH_COLON;
                            end
                        end else if (ch == CH_DOT) begin
                            if (!n_dec || n_wpos > 5'd12 || !n_ohd || n_ocnt >= 3'd4) begin
                                n_ph = PH_FAIL;
                            end else begin
                                n_bytes = put_byte(n_bytes,
                                                   n_wpos[3:0] + {1'b0, n_ocnt} - 4'd1,
                                                   n_oct);
                                n_oct = '0; n_ohd = 1'b0;
                                n_ph = PH_DOTTED;
                            end
                        end else begin
                            n_ph = PH_FAIL;
                        end
                    end
                    PH_DOTTED: begin
                        base = (n_fam == FAM_V4) ? 5'd0 : n_wpos;
                        if (ch >= 8'h30 && ch <= 8'h39) begin
                            dn = {4'd0, n_oct} * 12'd10 + {8'd0, ch[3:0]};
                            if ((n_ohd && n_oct == 8'd0) || dn > 12'd255
                                || (!n_ohd && n_ocnt >= 3'd4)) begin
                                ok = 1'b0;
                            end else begin
                                n_oct = dn[7:0];
                                if (!n_ohd) begin
                                    n_ocnt = n_ocnt + 3'd1; n_ohd = 1'b1;
                                end
                            end
                        end else if (ch == CH_DOT) begin
                            if (!n_ohd || n_ocnt >= 3'd4) begin
                                ok = 1'b0;
                            end else begin
                                n_bytes = put_byte(n_bytes,
                                                   base[3:0] + {1'b0, n_ocnt} - 4'd1,
                                                   n_oct);
                                n_oct = '0; n_ohd = 1'b0;
                            end
                        end else begin
                            ok = 1'b0;
                        end
                        if (!ok) n_ph = PH_FAIL;
                    end
                    PH_FAIL: begin
                    end
                    default: n_ph = PH_FAIL;
                endcase
            end
        end
        if (i_cmd.start_shift) begin
            shift_ok = (r_fam == FAM_V6) && r_gap && (r_st == ST_OK);
        end
        if (i_cmd.load_out) begin
            n_ph = PH_START;
        end
        // Zero-fill: bytes from the gap onward move to the end of the address.
        nshift = 5'd16 - r_wpos;
        lowmask = ~(128'h0) >> {r_gpos, 3'b000};
        kept = r_bytes & ~lowmask;
        moved = (r_bytes & lowmask) >> {nshift, 3'b000};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_START;
            r_fam <= '0;
            r_st <= '0;
            r_wpos <= '0;
            r_gpos <= '0;
            r_gap <= 1'b0;
            r_ghd <= 1'b0;
            r_ocnt <= '0;
            r_ohd <= 1'b0;
            r_dec <= 1'b1;
        end else begin
            r_ph <= n_ph;
            r_fam <= n_fam;
            r_st <= n_st;
            r_wpos <= n_wpos;
            r_gpos <= n_gpos;
            r_gap <= n_gap;
            r_ghd <= n_ghd;
            r_ocnt <= n_ocnt;
            r_ohd <= n_ohd;
            r_dec <= n_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        r_oct <= n_oct;
        if (i_cmd.start_shift && shift_ok) begin
            r_bytes <= kept | moved;
        end else begin
            r_bytes <= n_bytes;
        end
        if (i_cmd.load_out) begin
            r_status <= r_st;
            if (r_st != ST_OK) begin
                r_addr <= '0;
            end else if (r_fam == FAM_V4) begin
                r_addr <= {96'd0, r_bytes[127:96]};
            end else begin
                r_addr <= r_bytes;
            end
        end
    end

    assign o_status = r_status;
    assign o_address_high = r_addr[127:64];
    assign o_address_low = r_addr[63:0];
endmodule
`default_nettype wire

@@ hdl/iatp_ctrl.sv @@
`default_nettype none
module iatp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire logic             i_stall,
    input  wire iatp_pkg::t_sts   i_sts,
    output iatp_pkg::t_cmd        o_cmd
);
    import iatp_pkg::*;

    t_ctrl r_state, n_state;
    logic  r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CT_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ovalid = r_ovalid;
        o_cmd = '0;
        o_stall = 1'b1;
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        unique case (r_state)
            CT_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.term) n_state = CT_SHIFT;
                end
            end
            CT_SHIFT: begin
                o_cmd.start_shift = 1'b1;
                n_state = CT_OUT;
            end
            CT_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = CT_IDLE;
                end
            end
            default: n_state = CT_IDLE;
        endcase
    end

    assign o_valid = r_ovalid;
endmodule
`default_nettype wire

@@ hdl/ip_address_text_parser.sv @@
// IPv4/IPv6 address text parser.
// The input channel carries one character per beat together with a family
// code; the family of the first beat of a string applies to the whole string.
// A zero character terminates the string and produces one output beat with a
// status and the 128-bit address split over two 64-bit ports.
// Ordinary characters are accepted one per cycle while the input is not stalled.
// After the terminator beat is accepted, the parser passes through a shift
// state for the zero-fill shift of the address bytes and an output state
// that loads the output register, from which the result is driven.
// The input is stalled in both states, and it stays stalled while
// the new result waits for an earlier one still held in the output register.
// A result stays valid and unchanged while the receiver stalls.
// After reset, no result is pending and the parser waits for a new string.
`default_nettype none
module ip_address_text_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_character,
    input  wire logic [1:0]  i_family,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [63:0]      o_address_high,
    output logic [63:0]      o_address_low
);
    import iatp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    iatp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .i_sts(sts), .o_cmd(cmd)
    );

    iatp_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_character(i_character),
        .i_family(i_family), .o_sts(sts), .o_status(o_status),
        .o_address_high(o_address_high), .o_address_low(o_address_low)
    );
endmodule
`default_nettype wire

@@ tb/ip_address_text_parser_checker.sv @@
`timescale 1ns / 1ps
module ip_address_text_parser_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_character,
    input  wire logic [1:0]  i_family,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_status,
    input  wire logic [63:0] i_address_high,
    input  wire logic [63:0] i_address_low,
    output int               o_failures,
    output int               o_pending
);
    import iatp_pkg::*;

    typedef struct {
        t_status     status;
        logic [63:0] high;
        logic [63:0] low;
    } t_addr_result;

    t_addr_result addr_expected[$];

    logic [7:0] bytes_q[16];
    int         wr_pos;
    int         gap_pos;
    bit         gap_seen;
    int         grp_val;
    bit         grp_digit;
    int         oct_val;
    int         oct_cnt;
    bit         oct_digit;
    bit         tok_decimal;
    t_phase     phase;
    logic [1:0] str_family;

    function automatic void decimal_clear();
        oct_val = 0;
        oct_cnt = 0;
        oct_digit = 0;
        tok_decimal = 1;
    endfunction

    function automatic void string_clear();
        foreach (bytes_q[i]) bytes_q[i] = 8'h00;
        wr_pos = 0;
        gap_pos = 0;
        gap_seen = 0;
        grp_val = 0;
        grp_digit = 0;
        decimal_clear();
    endfunction

    function automatic bit octet_digit(int d);
        int n;
        if (oct_digit && oct_val == 0) return 0;
        n = oct_val * 10 + d;
        if (n > 255) return 0;
        oct_val = n;
        if (!oct_digit) begin
            if (oct_cnt >= 4) return 0;
            oct_cnt++;
            oct_digit = 1;
        end
        return 1;
    endfunction

    function automatic bit octet_dot(int base);
        if (!oct_digit || oct_cnt >= 4) return 0;
        bytes_q[(base + oct_cnt - 1) & 15] = oct_val[7:0];
        oct_val = 0;
        oct_digit = 0;
        return 1;
    endfunction

    function automatic bit octet_end(int base);
        if (oct_cnt != 4 || !oct_digit) return 0;
        bytes_q[(base + 3) & 15] = oct_val[7:0];
        return 1;
    endfunction

    function automatic bit group_store();
        if (wr_pos > 14) return 0;
        bytes_q[wr_pos & 15] = grp_val[15:8];
        bytes_q[(wr_pos + 1) & 15] = grp_val[7:0];
        wr_pos += 2;
        grp_val = 0;
        grp_digit = 0;
        return 1;
    endfunction

    function automatic int hex_digit(logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return ch - "0";
        if (ch >= "a" && ch <= "f") return ch - "a" + 10;
        if (ch >= "A" && ch <= "F") return ch - "A" + 10;
        return -1;
    endfunction

    function automatic bit v6_close();
        int n;
        int src;
        if (phase == PH_DOTTED) begin
            if (!octet_end(wr_pos)) return 0;
            wr_pos += 4;
        end else if (phase == PH_BODY) begin
            if (grp_digit && !group_store()) return 0;
        end else begin
            return 0;
        end
        if (gap_seen) begin
            if (wr_pos >= 16 || gap_pos > wr_pos) return 0;
            n = wr_pos - gap_pos;
            for (int i = 1; i <= n; i++) begin
                src = (gap_pos + n - i) & 15;
                bytes_q[(16 - i) & 15] = bytes_q[src];
                bytes_q[src] = 8'h00;
            end
            wr_pos = 16;
        end
        return wr_pos == 16;
    endfunction

    function automatic t_addr_result string_close();
        t_addr_result r;
        r.status = ST_OK;
        r.high = '0;
        r.low = '0;
        if (str_family >= 2) begin
            r.status = ST_FAMILY;
        end else if (str_family == FAM_V4) begin
            if (phase == PH_DOTTED && octet_end(0)) begin
                for (int i = 0; i < 4; i++) r.low = {r.low[55:0], bytes_q[i]};
            end else begin
                r.status = ST_BAD;
            end
        end else if (v6_close()) begin
            for (int i = 0; i < 8; i++) begin
                r.high = {r.high[55:0], bytes_q[i]};
                r.low = {r.low[55:0], bytes_q[i + 8]};
            end
        end else begin
            r.status = ST_BAD;
        end
        string_clear();
        phase = PH_START;
        return r;
    endfunction

    function automatic void v6_char(logic [7:0] ch);
        int h;
        h = hex_digit(ch);
        phase = PH_BODY;
        if (h >= 0) begin
            if (grp_val > 'hfff) begin
                phase = PH_FAIL;
                return;
            end
            grp_val = ((grp_val << 4) | h) & 'hffff;
            grp_digit = 1;
            if (tok_decimal && (h > 9 || ch > "9" || !octet_digit(h))) tok_decimal = 0;
        end else if (ch == CH_COLON) begin
            decimal_clear();
            if (!grp_digit) begin
                if (gap_seen) begin
                    phase = PH_FAIL;
                    return;
                end
                gap_seen = 1;
                gap_pos = wr_pos;
            end else begin
                if (!group_store()) begin
                    phase = PH_FAIL;
                    return;
                end
                phase = PH_COLON;
            end
        end else if (ch == CH_DOT) begin
            if (!tok_decimal || wr_pos > 12 || !octet_dot(wr_pos)) phase = PH_FAIL;
            else phase = PH_DOTTED;
        end else begin
            phase = PH_FAIL;
        end
    endfunction

    function automatic void parse_beat(logic [7:0] ch, logic [1:0] fam);
        bit ok;
        if (phase == PH_START) begin
            string_clear();
            str_family = fam;
            phase = (fam == FAM_V4) ? PH_DOTTED : (fam == FAM_V6) ? PH_BODY : PH_FAIL;
            if (ch == CH_COLON && phase == PH_BODY) begin
                phase = PH_LEAD;
                return;
            end
        end
        if (ch == CH_NUL) begin
            addr_expected.push_back(string_close());
            return;
        end
        case (phase)
            PH_LEAD: begin
                if (ch == CH_COLON) begin
                    gap_seen = 1;
                    gap_pos = 0;
                    phase = PH_BODY;
                end else begin
                    phase = PH_FAIL;
                end
            end
            PH_BODY, PH_COLON: v6_char(ch);
            PH_DOTTED: begin
                if (ch >= "0" && ch <= "9") ok = octet_digit(ch - "0");
                else if (ch == CH_DOT) ok = octet_dot(str_family == FAM_V4 ? 0 : wr_pos);
                else ok = 0;
                if (!ok) phase = PH_FAIL;
            end
            PH_FAIL: ;
            default: phase = PH_FAIL;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_addr_result e;
        if (!i_rst_n) begin
            string_clear();
            phase = PH_START;
            str_family = FAM_V4;
            addr_expected.delete();
            o_failures = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (addr_expected.size() == 0) begin
                    o_failures++;
                    if (o_failures <= 10) $display("unexpected result beat: status %0d", i_status);
                end else begin
                    e = addr_expected.pop_front();
                    if (i_status !== e.status || i_address_high !== e.high
                        || i_address_low !== e.low) begin
                        o_failures++;
                        if (o_failures <= 10)
                            $display("mismatch: expected %0d %h %h, got %0d %h %h",
                                     e.status, e.high, e.low,
                                     i_status, i_address_high, i_address_low);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) parse_beat(i_character, i_family);
        end
        o_pending = addr_expected.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import iatp_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [7:0]  i_character = 0;
    logic [1:0]  i_family = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [1:0]  o_status;
    logic [63:0] o_address_high;
    logic [63:0] o_address_low;
    int          failures;
    int          pending;
    int          cycles = 0;
    int          sent = 0;
    bit          calm = 0;
    int          stall_left = 0;
    byte         text[$];

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    ip_address_text_parser dut (.*);

    ip_address_text_parser_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_character(i_character), .i_family(i_family),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_status(o_status), .i_address_high(o_address_high),
        .i_address_low(o_address_low),
        .o_failures(failures), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            i_stall <= 1;
            stall_left <= $urandom_range(1, 14);
        end else begin
            i_stall <= 0;
            if (!calm && $urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 14);
        end
    end

    task automatic put_beat(logic [7:0] ch, logic [1:0] fam);
        i_valid <= 1;
        i_character <= ch;
        i_family <= fam;
        do @(posedge i_clk); while (o_stall);
        sent++;
        if (!calm && $urandom_range(0, 6) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic send_text(logic [1:0] fam);
        foreach (text[i]) put_beat(text[i], i == 0 ? fam : 2'($urandom));
        put_beat(CH_NUL, text.size() == 0 ? fam : 2'($urandom));
    endtask

    task automatic send_string(string s, logic [1:0] fam);
        text.delete();
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
        send_text(fam);
    endtask

    function automatic string v4_text();
        return $sformatf("%0d.%0d.%0d.%0d", $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    function automatic string group_text();
        logic [15:0] g;
        case ($urandom_range(0, 3))
            0: g = 16'h0;
            1: g = 16'($urandom_range(0, 15));
            default: g = 16'($urandom);
        endcase
        return $urandom_range(0, 3) == 0 ? $sformatf("%04h", g) : $sformatf("%0h", g);
    endfunction

    function automatic string v6_text();
        string tok[$];
        string s;
        int n;
        int gs;
        int gl;
        bit tail;
        tail = $urandom_range(0, 3) == 0;
        n = tail ? 6 : 8;
        for (int i = 0; i < n; i++) tok.push_back(group_text());
        gs = -1;
        gl = 0;
        if ($urandom_range(0, 2) != 0) begin
            gs = $urandom_range(0, n - 1);
            gl = $urandom_range(1, n - gs);
        end
        s = "";
        for (int i = 0; i < n; i++) begin
            if (i == gs) s = {s, "::"};
            if (i >= gs && i < gs + gl) continue;
            if (s.len() > 0 && s.substr(s.len() - 1, s.len() - 1) != ":") s = {s, ":"};
            s = {s, tok[i]};
        end
        if (tail) begin
            if (s.len() > 0 && s.substr(s.len() - 1, s.len() - 1) != ":") s = {s, ":"};
            s = {s, v4_text()};
        end
        return s;
    endfunction

    task automatic send_random();
        string s;
        string pick;
        logic [1:0] fam;
        int k;
        pick = ":.0123456789afAF";
        fam = $urandom_range(0, 1);
        s = fam == FAM_V4 ? v4_text() : v6_text();
        text.delete();
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] >= "a" && s[i] <= "f" && $urandom_range(0, 1)) text.push_back(s[i] - 32);
            else text.push_back(s[i]);
        end
        if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, text.size());
            case ($urandom_range(0, 2))
                0: if (k < text.size()) text[k] = 8'($urandom_range(1, 255));
                1: if (k < text.size()) text.delete(k);
                default: text.insert(k, pick[$urandom_range(0, 15)]);
            endcase
        end
        if ($urandom_range(0, 9) == 0) fam = $urandom_range(0, 3);
        send_text(fam);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        send_string("1.2.3.4", FAM_V4);
        send_string("255.255.255.255", FAM_V4);
        send_string("0.0.0.0", FAM_V4);
        send_string("01.2.3.4", FAM_V4);
        send_string("256.1.1.1", FAM_V4);
        send_string("1.2.3.4.5", FAM_V4);
        send_string("1..2.3", FAM_V4);
        send_string("1.2.3.", FAM_V4);
        send_string("", FAM_V4);
        send_string("", FAM_V6);
        send_string("1.2.3.4", 2'd2);
        send_string("::", 2'd3);
        send_string("::", FAM_V6);
        send_string("::1", FAM_V6);
        send_string("ffff:FFFF:abcd:0:0:0:0:1", FAM_V6);
        send_string("00001:2:3:4:5:6:7:8", FAM_V6);
        send_string("10000::", FAM_V6);
        send_string(":1::", FAM_V6);
        send_string("1:2:3:4:5:6:7:", FAM_V6);
        send_string("1::2::3", FAM_V6);
        send_string("1:2:3:4:5:6:7:8::", FAM_V6);
        send_string("1:2:3:4:5:6:7", FAM_V6);
        send_string("::ffff:1.2.3.4", FAM_V6);
        send_string("1:2:3:4:5:6:7:1.2.3.4", FAM_V6);
        text = {8'h67, 8'h80, 8'hff, 8'h3a};
        send_text(FAM_V6);
        while (sent < 1050) begin
            if (sent > 900) calm = 1;
            send_random();
        end
        i_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/iatp_pkg.sv
hdl/iatp_datapath.sv
hdl/iatp_ctrl.sv
hdl/ip_address_text_parser.sv
tb/ip_address_text_parser_checker.sv
tb/tb_top.sv
